// File: rtl/core/krt_pkg.sv
`timescale 1ns / 1ps

package krt_pkg;

  localparam int KEY_W    = 31;
  localparam int AGE_W    = 8;
  localparam int GRADE_W  = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LIST   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LIST,
    S_EMIT,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [AGE_W-1:0]   age;
    logic [GRADE_W-1:0] grade;
  } rec_t;

  typedef struct packed {
    status_e status;
    rec_t    rec;
    logic    last;
  } res_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// File: rtl/core/krt_if.sv
`timescale 1ns / 1ps

interface krt_in_if
  import krt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   record_key;
  logic [AGE_W-1:0]   record_age;
  logic [GRADE_W-1:0] record_grade;

  modport source (
    output valid, operation, record_key, record_age, record_grade,
    input  ready
  );

  modport sink (
    input  valid, operation, record_key, record_age, record_grade,
    output ready
  );
endinterface

interface krt_out_if
  import krt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [AGE_W-1:0]    out_age;
  logic [GRADE_W-1:0]  out_grade;
  logic                last;

  modport source (
    output valid, status, out_key, out_age, out_grade, last,
    input  ready
  );

  modport sink (
    input  valid, status, out_key, out_age, out_grade, last,
    output ready
  );
endinterface

// File: rtl/core/keyed_record_table_unit.sv
`timescale 1ns / 1ps

// Record table of up to CAPACITY entries (key, age, grade) kept in insertion
// order in one single-port-read record memory. Add, search and delete scan the
// table one entry per cycle (an add to a full or empty table needs no scan);
// a delete then moves the later entries down one per cycle. A list reads and
// emits one entry at a time, the next only once the last result is taken.
// The memory gives one registered read per cycle. Input is not taken while an
// operation runs; each result goes through an output register, so the next
// operation may start while the previous result still waits to be taken.
module keyed_record_table_unit
  import krt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_in_if.sink    req_i,
  krt_out_if.source rsp_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  rec_t          in_rec;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic [IW-1:0] ram_raddr;
  rec_t          ram_rdata;

  logic          out_valid_q, out_valid_d;
  res_t          out_q;

  assign in_rec = '{key: req_i.record_key, age: req_i.record_age,
                    grade: req_i.record_grade};

  krt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_op_i     (req_i.operation),
    .in_rec_i    (in_rec),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  krt_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: take a new result when empty or being drained
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.out_key   = out_q.rec.key;
  assign rsp_o.out_age   = out_q.rec.age;
  assign rsp_o.out_grade = out_q.rec.grade;
  assign rsp_o.last      = out_q.last;

endmodule

// File: rtl/core/krt_ram.sv
`timescale 1ns / 1ps

module krt_ram #(
  parameter int WIDTH = 47,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/krt_ctrl.sv
`timescale 1ns / 1ps

module krt_ctrl
  import krt_pkg::*;
#(
  parameter int CAPACITY = 64,
  localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] in_op_i,
  input  rec_t            in_rec_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output res_t            res_o,
  output logic            ram_we_o,
  output logic [IW-1:0]   ram_waddr_o,
  output rec_t            ram_wdata_o,
  output logic [IW-1:0]   ram_raddr_o,
  input  rec_t            ram_rdata_i
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  rec_t          req_q, req_d;
  res_t          res_q, res_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;

  op_e           in_op;
  logic          cnt_zero;
  logic          cnt_full;
  logic          idx_last;
  logic          hit;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_inc2;

  assign in_op    = op_e'(in_op_i);
  assign cnt_zero = (count_q == '0);
  assign cnt_full = (count_q == CW'(CAPACITY));
  assign idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
  assign hit      = (ram_rdata_i.key == req_q.key);
  assign idx_inc  = IW'({1'b0, idx_q} + (IW+1)'(1));
  assign idx_inc2 = IW'({1'b0, idx_q} + (IW+1)'(2));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op)
            OP_ADD:  state_d = (cnt_full || cnt_zero) ? S_EMIT : S_SCAN;
            OP_LIST: state_d = cnt_zero ? S_EMIT : S_LIST;
            default: state_d = cnt_zero ? S_EMIT : S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (hit || idx_last) begin
          state_d = S_EMIT;
        end
      end
      S_LIST: state_d = S_EMIT;
      S_EMIT: begin
        if (res_ready_i) begin
          if (op_q == OP_DELETE && res_q.status == ST_OK) begin
            state_d = S_SHIFT;
          end else if (op_q == OP_LIST && !res_q.last) begin
            state_d = S_LIST;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        if (idx_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    req_d       = req_q;
    res_d       = res_q;
    idx_d       = idx_q;
    count_d     = count_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = ram_rdata_i;
    // read one entry ahead so the data is there when the index advances
    ram_raddr_o = idx_inc;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ram_raddr_o = '0;
        if (in_valid_i) begin
          op_d  = in_op;
          req_d = in_rec_i;
          idx_d = '0;
          unique case (in_op)
            OP_ADD: begin
              if (cnt_full) begin
                res_d = '{status: ST_FULL, rec: '0, last: 1'b1};
              end else if (cnt_zero) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = '0;
                ram_wdata_o = in_rec_i;
                count_d     = count_q + CW'(1);
                res_d       = '{status: ST_OK, rec: in_rec_i, last: 1'b1};
              end
            end
            OP_LIST: begin
              if (cnt_zero) begin
                res_d = '{status: ST_EMPTY, rec: '0, last: 1'b1};
              end
            end
            default: begin
              if (cnt_zero) begin
                res_d = '{status: ST_NOTFOUND, rec: '0, last: 1'b1};
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_d = '{status: (op_q == OP_ADD) ? ST_DUP : ST_OK,
                    rec: ram_rdata_i, last: 1'b1};
        end else if (idx_last) begin
          if (op_q == OP_ADD) begin
            // append behind the last entry
            ram_we_o    = 1'b1;
            ram_waddr_o = IW'(count_q);
            ram_wdata_o = req_q;
            count_d     = count_q + CW'(1);
            res_d       = '{status: ST_OK, rec: req_q, last: 1'b1};
          end else begin
            res_d = '{status: ST_NOTFOUND, rec: '0, last: 1'b1};
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      S_LIST: begin
        res_d = '{status: ST_OK, rec: ram_rdata_i, last: idx_last};
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i && op_q == OP_LIST && !res_q.last) begin
          idx_d = idx_inc;
        end
      end
      S_SHIFT: begin
        if (idx_last) begin
          count_d = count_q - CW'(1);
        end else begin
          // move entry idx+1 down to idx
          ram_we_o    = 1'b1;
          ram_waddr_o = idx_q;
          ram_wdata_o = ram_rdata_i;
          ram_raddr_o = idx_inc2;
          idx_d       = idx_inc;
        end
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      op_q    <= OP_ADD;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

endmodule
